[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks shared by the touch sampler RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, held off while reset is low.
`define TSAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that holds at every clock edge out of reset.
`define TSAC_INVARIANT(lbl, expr, msg) \
  `TSAC_ASSERT(lbl, (expr), msg)

`endif

[design/tsac_pkg.sv]
// ---------------------------------------------------------------------------
// tsac_pkg
// Types, widths, register map and helpers of the touch sampler core.
// ---------------------------------------------------------------------------
package tsac_pkg;

  localparam int unsigned SAMPLE_COUNT_DEF = 8;

  localparam int unsigned COORD_W   = 12;
  localparam int unsigned COORD_MAX = 4095;
  localparam int unsigned RING_W    = 2 * COORD_W;
  localparam int unsigned COEF_W    = 24;
  localparam int unsigned FRAC_W    = 20;
  localparam int unsigned OFF_SHIFT = 8;
  localparam int unsigned PROD_W    = COEF_W + COORD_W + 1;
  localparam int unsigned ACC_W     = PROD_W + 1;

  localparam int unsigned PADDR_W   = 5;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_CAL_MODE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_XX  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_XY  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_X = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_YX  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_YY  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y = 3'd6;

  localparam logic signed [COEF_W-1:0] GAIN_XX_RST  = -24'sd979;
  localparam logic signed [COEF_W-1:0] GAIN_XY_RST  = -24'sd66777;
  localparam logic signed [COEF_W-1:0] OFFSET_X_RST = 24'sd1025401;
  localparam logic signed [COEF_W-1:0] GAIN_YX_RST  = -24'sd93300;
  localparam logic signed [COEF_W-1:0] GAIN_YY_RST  = -24'sd1238;
  localparam logic signed [COEF_W-1:0] OFFSET_Y_RST = 24'sd1460380;

  typedef enum logic [1:0] {
    PH_IDLE        = 2'd0,
    PH_PRESAMPLING = 2'd1,
    PH_TOUCHED     = 2'd2,
    PH_RELEASED    = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_SUM,
    ST_STORE,
    ST_DIV_MUL,
    ST_DIV_FIX,
    ST_DONE
  } seq_e;

  // Offset in Q11.12 lifted to the Q.20 accumulator scale.
  function automatic logic signed [ACC_W-1:0] offset_ext(input logic signed [COEF_W-1:0] off);
    offset_ext = {{(ACC_W - COEF_W - OFF_SHIFT){off[COEF_W-1]}}, off, {OFF_SHIFT{1'b0}}};
  endfunction

  // Floor by 2^20, then clamp to the coordinate range.
  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [ACC_W-1:0] acc);
    if (acc[ACC_W-1]) begin
      sat_coord = '0;
    end else if (|acc[ACC_W-2:FRAC_W+COORD_W]) begin
      sat_coord = COORD_W'(COORD_MAX);
    end else begin
      sat_coord = acc[FRAC_W+COORD_W-1:FRAC_W];
    end
  endfunction

endpackage

[design/tsac_ram.sv]
// ---------------------------------------------------------------------------
// tsac_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module tsac_ram #(
  parameter int unsigned WIDTH = tsac_pkg::RING_W,
  parameter int unsigned DEPTH = tsac_pkg::SAMPLE_COUNT_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/touch_sampler_averaging_calibrated_core.sv]
// ---------------------------------------------------------------------------
// touch_sampler_averaging_calibrated_core
// Touch front end: pen phase tracking, affine calibration, ring averaging.
// ---------------------------------------------------------------------------
// Sequence: a stored sample raises its result once accepted, through
//   two multiply steps, accumulate, store, two divide steps, result load.
// Other requests (pen-down, idle poll, release) go straight to the result load.
// One request at a time, set by the read-modify-write sequencer; the result
//   load waits for a free output, and the next request is taken after it.
// Reset: phase idle, write slot 0, ring reads as zero at once (valid bits),
//   running sums and averages zero, registers at their calibration defaults.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module touch_sampler_averaging_calibrated_core #(
  parameter int unsigned SAMPLE_COUNT = tsac_pkg::SAMPLE_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tsac_pkg::PADDR_W-1:0]   paddr,
  input  logic [tsac_pkg::PDATA_W-1:0]   pwdata,
  output logic [tsac_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           opcode_i,
  input  logic [tsac_pkg::COORD_W-1:0]   raw_x_i,
  input  logic [tsac_pkg::COORD_W-1:0]   raw_y_i,
  input  logic                           pen_up_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     touch_state_o,
  output logic                           touched_o,
  output logic [tsac_pkg::COORD_W-1:0]   avg_x_o,
  output logic [tsac_pkg::COORD_W-1:0]   avg_y_o
);

  localparam int unsigned COORD_W = tsac_pkg::COORD_W;
  localparam int unsigned SLOT_W  = $clog2(SAMPLE_COUNT);
  localparam int unsigned SUM_W   = $clog2(SAMPLE_COUNT * (tsac_pkg::COORD_MAX + 1));
  localparam int unsigned DPROD_W = 2 * SUM_W;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SAMPLE_COUNT - 1);
  localparam logic [SUM_W-1:0]  N_SUM     = SUM_W'(SAMPLE_COUNT);
  localparam logic [SUM_W-1:0]  SUM_MAX   = SUM_W'(SAMPLE_COUNT * tsac_pkg::COORD_MAX);
  // floor(2^SUM_W / N): the quotient estimate is at most one below the true one
  localparam logic [SUM_W-1:0]  RECIP     = SUM_W'((1 << SUM_W) / SAMPLE_COUNT);

  // ------------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------------
  logic                                cal_mode_q;
  logic signed [tsac_pkg::COEF_W-1:0]  gxx_q, gxy_q, offx_q, gyx_q, gyy_q, offy_q;
  logic [tsac_pkg::REG_IDX_W-1:0]      cfg_idx;
  logic                                cfg_we;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[tsac_pkg::PADDR_W-1:2];
  assign cfg_we  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_mode_q <= 1'b0;
      gxx_q      <= tsac_pkg::GAIN_XX_RST;
      gxy_q      <= tsac_pkg::GAIN_XY_RST;
      offx_q     <= tsac_pkg::OFFSET_X_RST;
      gyx_q      <= tsac_pkg::GAIN_YX_RST;
      gyy_q      <= tsac_pkg::GAIN_YY_RST;
      offy_q     <= tsac_pkg::OFFSET_Y_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tsac_pkg::REG_CAL_MODE: cal_mode_q <= pwdata[0];
        tsac_pkg::REG_GAIN_XX:  gxx_q      <= pwdata[tsac_pkg::COEF_W-1:0];
        tsac_pkg::REG_GAIN_XY:  gxy_q      <= pwdata[tsac_pkg::COEF_W-1:0];
        tsac_pkg::REG_OFFSET_X: offx_q     <= pwdata[tsac_pkg::COEF_W-1:0];
        tsac_pkg::REG_GAIN_YX:  gyx_q      <= pwdata[tsac_pkg::COEF_W-1:0];
        tsac_pkg::REG_GAIN_YY:  gyy_q      <= pwdata[tsac_pkg::COEF_W-1:0];
        tsac_pkg::REG_OFFSET_Y: offy_q     <= pwdata[tsac_pkg::COEF_W-1:0];
        default: ;  // drop writes beyond the register map
      endcase
    end
  end

  // Read back: coefficients zero-extended to the bus width.
  always_comb begin
    unique case (cfg_idx)
      tsac_pkg::REG_CAL_MODE: prdata = {{(tsac_pkg::PDATA_W-1){1'b0}}, cal_mode_q};
      tsac_pkg::REG_GAIN_XX:  prdata = {8'h00, gxx_q};
      tsac_pkg::REG_GAIN_XY:  prdata = {8'h00, gxy_q};
      tsac_pkg::REG_OFFSET_X: prdata = {8'h00, offx_q};
      tsac_pkg::REG_GAIN_YX:  prdata = {8'h00, gyx_q};
      tsac_pkg::REG_GAIN_YY:  prdata = {8'h00, gyy_q};
      tsac_pkg::REG_OFFSET_Y: prdata = {8'h00, offy_q};
      default:                prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------------
  // Sequencer and phase tracking
  // ------------------------------------------------------------------------
  tsac_pkg::seq_e   state_q, state_d;
  tsac_pkg::phase_e phase_q, phase_d;
  logic [SLOT_W-1:0] write_slot_q, write_slot_d;
  logic              accept, store_req, slot_last, out_load;
  logic              out_valid_q, out_valid_d;

  assign in_ready_o = (state_q == tsac_pkg::ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign store_req  = opcode_i & ((phase_q == tsac_pkg::PH_PRESAMPLING) |
                                  (phase_q == tsac_pkg::PH_TOUCHED));
  assign slot_last  = (write_slot_q == LAST_SLOT);
  // Load the result register once it is free or being emptied this cycle.
  assign out_load   = (state_q == tsac_pkg::ST_DONE) & (~out_valid_q | out_ready_i);

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    write_slot_d = write_slot_q;
    out_valid_d  = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      tsac_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = store_req ? tsac_pkg::ST_MUL : tsac_pkg::ST_DONE;
          if (!opcode_i) begin
            // pen-down: restart presampling, keep the ring and the slot
            phase_d = tsac_pkg::PH_PRESAMPLING;
          end else begin
            unique case (phase_q)
              tsac_pkg::PH_PRESAMPLING: begin
                write_slot_d = slot_last ? '0 : write_slot_q + 1'b1;
                if (slot_last) begin
                  phase_d = tsac_pkg::PH_TOUCHED;
                end
                if (pen_up_i) begin
                  phase_d = tsac_pkg::PH_RELEASED;
                end
              end
              tsac_pkg::PH_TOUCHED: begin
                write_slot_d = slot_last ? '0 : write_slot_q + 1'b1;
                if (pen_up_i) begin
                  phase_d = tsac_pkg::PH_RELEASED;
                end
              end
              tsac_pkg::PH_RELEASED: begin
                phase_d      = tsac_pkg::PH_IDLE;
                write_slot_d = '0;
              end
              tsac_pkg::PH_IDLE: ;  // poll while idle: nothing moves
            endcase
          end
        end
      end
      tsac_pkg::ST_MUL:     state_d = tsac_pkg::ST_ACC;
      tsac_pkg::ST_ACC:     state_d = tsac_pkg::ST_SUM;
      tsac_pkg::ST_SUM:     state_d = tsac_pkg::ST_STORE;
      tsac_pkg::ST_STORE:   state_d = tsac_pkg::ST_DIV_MUL;
      tsac_pkg::ST_DIV_MUL: state_d = tsac_pkg::ST_DIV_FIX;
      tsac_pkg::ST_DIV_FIX: state_d = tsac_pkg::ST_DONE;
      tsac_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = tsac_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tsac_pkg::ST_IDLE;
      phase_q      <= tsac_pkg::PH_IDLE;
      write_slot_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      write_slot_q <= write_slot_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // ------------------------------------------------------------------------
  // Ring RAM: read the old entry at acceptance, write the new one in STORE
  // ------------------------------------------------------------------------
  logic [SLOT_W-1:0]           st_slot_q;
  logic [COORD_W-1:0]          rx_q, ry_q;
  logic [tsac_pkg::RING_W-1:0] ram_rdata, ram_wdata;
  logic                        ram_we;
  logic [SAMPLE_COUNT-1:0]     valid_q;
  logic [COORD_W-1:0]          old_x_q, old_y_q, new_x, new_y;

  assign ram_we    = (state_q == tsac_pkg::ST_STORE);
  assign ram_wdata = {new_x, new_y};

  // Only one request is in flight, so the write always lands before the
  // next read of the same slot: no forwarding path is needed.
  tsac_ram #(
    .WIDTH (tsac_pkg::RING_W),
    .DEPTH (SAMPLE_COUNT)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (st_slot_q),
    .wdata_i (ram_wdata),
    .raddr_i (write_slot_q),
    .rdata_o (ram_rdata)
  );

  // Entries never written since reset read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[st_slot_q] <= 1'b1;
    end
  end

  // ------------------------------------------------------------------------
  // Affine datapath, one multiplier per lane and step
  // ------------------------------------------------------------------------
  logic signed [tsac_pkg::PROD_W-1:0] px1_d, py1_d, px2_d, py2_d;
  logic signed [tsac_pkg::PROD_W-1:0] px1_q, py1_q, px2_q, py2_q;
  logic signed [tsac_pkg::ACC_W-1:0]  accx_q, accy_q;

  assign px1_d = gxx_q * $signed({1'b0, rx_q});
  assign py1_d = gyx_q * $signed({1'b0, rx_q});
  assign px2_d = gxy_q * $signed({1'b0, ry_q});
  assign py2_d = gyy_q * $signed({1'b0, ry_q});

  assign new_x = cal_mode_q ? rx_q : tsac_pkg::sat_coord(accx_q);
  assign new_y = cal_mode_q ? ry_q : tsac_pkg::sat_coord(accy_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rx_q      <= raw_x_i;
      ry_q      <= raw_y_i;
      st_slot_q <= write_slot_q;
    end
    unique case (state_q)
      tsac_pkg::ST_MUL: begin
        px1_q   <= px1_d;
        py1_q   <= py1_d;
        old_x_q <= valid_q[st_slot_q] ? ram_rdata[tsac_pkg::RING_W-1:COORD_W] : '0;
        old_y_q <= valid_q[st_slot_q] ? ram_rdata[COORD_W-1:0] : '0;
      end
      tsac_pkg::ST_ACC: begin
        px2_q  <= px2_d;
        py2_q  <= py2_d;
        accx_q <= tsac_pkg::ACC_W'(px1_q) + tsac_pkg::offset_ext(offx_q);
        accy_q <= tsac_pkg::ACC_W'(py1_q) + tsac_pkg::offset_ext(offy_q);
      end
      tsac_pkg::ST_SUM: begin
        accx_q <= accx_q + tsac_pkg::ACC_W'(px2_q);
        accy_q <= accy_q + tsac_pkg::ACC_W'(py2_q);
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------------------
  // Running sums and averages
  // ------------------------------------------------------------------------
  logic [SUM_W-1:0]   sum_x_q, sum_y_q, sum_x_d, sum_y_d;
  logic [DPROD_W-1:0] dprod_x_q, dprod_y_q;
  logic [COORD_W-1:0] q0_x, q0_y, avg_x_q, avg_y_q, avg_x_d, avg_y_d;
  logic [SUM_W-1:0]   rem_x, rem_y;

  // Swap the old entry out of the sum and the new one in.
  assign sum_x_d = sum_x_q + SUM_W'(new_x) - SUM_W'(old_x_q);
  assign sum_y_d = sum_y_q + SUM_W'(new_y) - SUM_W'(old_y_q);

  // Divide by the ring depth: reciprocal estimate, then one correction step.
  assign q0_x    = dprod_x_q[SUM_W +: COORD_W];
  assign q0_y    = dprod_y_q[SUM_W +: COORD_W];
  assign rem_x   = sum_x_q - SUM_W'(SUM_W'(q0_x) * N_SUM);
  assign rem_y   = sum_y_q - SUM_W'(SUM_W'(q0_y) * N_SUM);
  assign avg_x_d = q0_x + COORD_W'(rem_x >= N_SUM);
  assign avg_y_d = q0_y + COORD_W'(rem_y >= N_SUM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q <= '0;
      sum_y_q <= '0;
      avg_x_q <= '0;
      avg_y_q <= '0;
    end else begin
      if (state_q == tsac_pkg::ST_STORE) begin
        sum_x_q <= sum_x_d;
        sum_y_q <= sum_y_d;
      end
      if (state_q == tsac_pkg::ST_DIV_FIX) begin
        avg_x_q <= avg_x_d;
        avg_y_q <= avg_y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == tsac_pkg::ST_DIV_MUL) begin
      dprod_x_q <= DPROD_W'(sum_x_q) * DPROD_W'(RECIP);
      dprod_y_q <= DPROD_W'(sum_y_q) * DPROD_W'(RECIP);
    end
  end

  // ------------------------------------------------------------------------
  // Result register
  // ------------------------------------------------------------------------
  tsac_pkg::phase_e   res_state_q;
  logic [COORD_W-1:0] res_x_q, res_y_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_state_q <= phase_q;
      res_x_q     <= avg_x_q;
      res_y_q     <= avg_y_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign touch_state_o = res_state_q;
  assign touched_o     = (res_state_q == tsac_pkg::PH_TOUCHED);
  assign avg_x_o       = res_x_q;
  assign avg_y_o       = res_y_q;

  // ------------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------------
  `TSAC_ASSERT(a_store_starts_rmw, accept && store_req |=> state_q == tsac_pkg::ST_MUL, "no RMW")
  `TSAC_INVARIANT(a_slot_in_range, write_slot_q <= LAST_SLOT, "write slot beyond ring depth")
  `TSAC_INVARIANT(a_sums_bounded, sum_x_q <= SUM_MAX && sum_y_q <= SUM_MAX, "sum out of range")
  `TSAC_ASSERT(a_result_held, out_valid_q && !out_ready_i |=> out_valid_q && $stable(res_x_q), "lost")

endmodule
